### rtl/i2cbs_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
package i2cbs_pkg;

  localparam int MODE_W        = 3;
  localparam int BITS_PER_BYTE = 8;
  localparam int IN_TDATA_W    = 24;
  localparam int OUT_TDATA_W   = 16;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  // Command codes as they arrive on in_tuser; the two top codes are unused.
  typedef enum logic [MODE_W-1:0] {
    MODE_START = 3'd0,
    MODE_STOP  = 3'd1,
    MODE_WRITE = 3'd2,
    MODE_READ  = 3'd3,
    MODE_RACK  = 3'd4,
    MODE_SACK  = 3'd5
  } mode_t;

  typedef struct packed {
    mode_t                    mode;
    logic [BITS_PER_BYTE-1:0] tx_byte;
    logic                     ack_level;
    logic [BITS_PER_BYTE-1:0] bus_levels;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

### rtl/i2cbs_cmd_decode.sv
// Front end: accept command words, drop unused modes, push the rest.
module i2cbs_cmd_decode (
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [i2cbs_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [i2cbs_pkg::MODE_W-1:0]      in_tuser,
  input  i2cbs_pkg::queue_status_t          q_status,
  output logic                              push,
  output i2cbs_pkg::cmd_t                   push_cmd
);
  import i2cbs_pkg::*;

  logic mode_ok;

  always_comb begin
    unique case (in_tuser)
      MODE_START, MODE_STOP, MODE_WRITE,
      MODE_READ, MODE_RACK, MODE_SACK: mode_ok = 1'b1;
      default:                         mode_ok = 1'b0;
    endcase
  end

  assign in_tready = !q_status.full;
  // Unused modes are taken off the bus but never reach the queue.
  assign push      = in_tvalid && in_tready && mode_ok;

  assign push_cmd.mode       = mode_t'(in_tuser);
  assign push_cmd.tx_byte    = in_tdata[7:0];
  assign push_cmd.ack_level  = in_tdata[8];
  assign push_cmd.bus_levels = in_tdata[16:9];

endmodule

### rtl/i2cbs_cmd_queue.sv
// Short command queue between the decode front end and the event engine.
module i2cbs_cmd_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  i2cbs_pkg::cmd_t          push_cmd,
  input  logic                     pop,
  output i2cbs_pkg::cmd_t          head_cmd,
  output i2cbs_pkg::queue_status_t q_status
);
  import i2cbs_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign q_status.empty = (count_r == '0);
  assign q_status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_cmd       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### rtl/i2cbs_event_engine.sv
// Back end: step through one command and emit its pin events.
module i2cbs_event_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  i2cbs_pkg::cmd_t                   head_cmd,
  input  i2cbs_pkg::queue_status_t          q_status,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [i2cbs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                              out_tlast
);
  import i2cbs_pkg::*;

  localparam logic [2:0] LAST_BIT = 3'(BITS_PER_BYTE - 1);

  typedef enum logic {ENG_IDLE, ENG_RUN} eng_state_t;
  // Phase of the current bit: SDA setup, SCL high, SCL low / SDA edge, tail.
  typedef enum logic [1:0] {PH_SETUP, PH_HIGH, PH_LOW, PH_TAIL} phase_t;

  eng_state_t               state_r;
  phase_t                   ph_r, ph_nxt;
  logic [2:0]               bc_r;
  mode_t                    op_r;
  logic [BITS_PER_BYTE-1:0] shift_r;
  logic                     ackl_r;
  logic [BITS_PER_BYTE-1:0] bus_r;
  logic                     scl_r, sda_r;

  logic                     out_valid_r;
  logic                     out_scl_r, out_sda_r, out_last_r, out_ack_r;
  logic [BITS_PER_BYTE-1:0] out_rx_r;

  logic                     ev_is_sda, ev_level, ev_last, ev_ack;
  logic [BITS_PER_BYTE-1:0] ev_rx;
  logic                     byte_op, fire;

  assign byte_op = (op_r == MODE_WRITE) || (op_r == MODE_READ);

  always_comb begin
    ev_is_sda = 1'b0;
    ev_level  = 1'b1;
    ev_last   = 1'b0;
    ev_rx     = '0;
    ev_ack    = 1'b0;
    unique case (ph_r)
      PH_SETUP: begin
        ev_is_sda = 1'b1;
        unique case (op_r)
          MODE_STOP:  ev_level = 1'b0;
          MODE_WRITE: ev_level = shift_r[BITS_PER_BYTE-1];
          MODE_SACK:  ev_level = ackl_r;
          default:    ev_level = 1'b1;
        endcase
      end
      PH_HIGH: begin
        ev_level = 1'b1;
      end
      PH_LOW: begin
        priority case (op_r)
          MODE_START: begin
            ev_is_sda = 1'b1;
            ev_level  = 1'b0;
          end
          MODE_STOP: begin
            ev_is_sda = 1'b1;
            ev_level  = 1'b1;
            ev_last   = 1'b1;
          end
          default: begin
            ev_level = 1'b0;
            ev_last  = byte_op ? (bc_r == LAST_BIT) : 1'b1;
            ev_rx    = (op_r == MODE_READ && bc_r == LAST_BIT) ? bus_r : '0;
            ev_ack   = (op_r == MODE_RACK) ? bus_r[BITS_PER_BYTE-1] : 1'b0;
          end
        endcase
      end
      PH_TAIL: begin
        ev_level = 1'b0;
        ev_last  = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (ph_r)
      PH_SETUP: ph_nxt = PH_HIGH;
      PH_HIGH:  ph_nxt = PH_LOW;
      PH_LOW: begin
        priority case (op_r)
          MODE_WRITE: ph_nxt = PH_SETUP;
          MODE_READ:  ph_nxt = PH_HIGH;
          default:    ph_nxt = PH_TAIL;
        endcase
      end
      default:  ph_nxt = PH_SETUP;
    endcase
  end

  assign fire = (state_r == ENG_RUN) && (!out_valid_r || out_tready);
  assign pop  = (state_r == ENG_IDLE) && !q_status.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ENG_IDLE;
      out_valid_r <= 1'b0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      ph_r        <= PH_SETUP;
      bc_r        <= '0;
    end else begin
      priority if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end else begin
        out_valid_r <= out_valid_r;
      end
      unique case (state_r)
        ENG_IDLE: begin
          if (pop) begin
            op_r    <= head_cmd.mode;
            shift_r <= head_cmd.tx_byte;
            ackl_r  <= head_cmd.ack_level;
            bus_r   <= head_cmd.bus_levels;
            ph_r    <= PH_SETUP;
            bc_r    <= '0;
            state_r <= ENG_RUN;
          end
        end
        ENG_RUN: begin
          if (fire) begin
            if (ev_is_sda) begin
              sda_r <= ev_level;
            end else begin
              scl_r <= ev_level;
            end
            out_scl_r  <= ev_is_sda ? scl_r : ev_level;
            out_sda_r  <= ev_is_sda ? ev_level : sda_r;
            out_last_r <= ev_last;
            out_rx_r   <= ev_rx;
            out_ack_r  <= ev_ack;
            ph_r       <= ph_nxt;
            if (ph_r == PH_LOW && byte_op) begin
              bc_r    <= bc_r + 1'b1;
              shift_r <= {shift_r[BITS_PER_BYTE-2:0], 1'b0};
            end
            if (ev_last) begin
              state_r <= ENG_IDLE;
            end
          end
        end
        default: state_r <= ENG_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'b0, out_ack_r, out_rx_r, out_sda_r, out_scl_r};

endmodule

### rtl/i2c_master_bit_sequencer_core.sv
// Top level of the I2C master bit sequencer: decode, queue and event engine.
//
//  channel | dir | tdata (low bit up)                    | tuser     | tlast
//  --------+-----+---------------------------------------+-----------+-----------
//  in_     | in  | tx_byte[7:0] ack_level[8] bus[16:9]   | mode[2:0] | -
//  out_    | out | scl[0] sda[1] rx_byte[9:2] ack_in[10] | -         | last_event
//
// Each command is loaded from the queue into the event engine, which then
// emits one pin event per cycle unless out_tready stalls it: 4 for start,
// 3 for stop, read ack and send ack, 17 for read byte, 24 for write byte. The
// engine emits at most one event a cycle into a single output register.
// Reset is synchronous, active low, and drives both pins to released (high).
// A stalled out_tready freezes the engine; the two-entry queue keeps taking
// command words until it fills. Unused modes are accepted and dropped.
module i2c_master_bit_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // tx_byte[7:0], ack_level[8], bus_levels[16:9], zero pad
  input  logic [2:0]  in_tuser,   // mode[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // scl_out[0], sda_out[1], rx_byte[9:2], ack_in[10], zero pad
  output logic        out_tlast   // last_event
);
  import i2cbs_pkg::*;

  cmd_t          push_cmd;
  cmd_t          head_cmd;
  queue_status_t q_status;
  logic          push;
  logic          pop;

  // Classify incoming words and push real commands.
  i2cbs_cmd_decode u_decode (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Hold pending commands so the front end keeps flowing during long runs.
  i2cbs_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_status (q_status)
  );

  // Advance through the pin events of the command at the queue head.
  i2cbs_event_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_cmd   (head_cmd),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### rtl/i2cbs_checker.sv
// Port-level checks for the I2C master bit sequencer, bound to the top level.
module i2cbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  logic [1:0] prev_pins_r;
  logic       have_prev_r;

  // Track the pin levels of the last delivered event word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_pins_r <= 2'b11;
    end else if (out_tvalid && out_tready) begin
      have_prev_r <= 1'b1;
      prev_pins_r <= out_tdata[1:0];
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output word changed");

  a_rx_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> (out_tdata[10:2] == 9'd0))
    else $error("received data shown before the last event");

  a_one_pin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && have_prev_r |-> ($countones(out_tdata[1:0] ^ prev_pins_r) <= 1))
    else $error("event moved both pins at once");

endmodule

bind i2c_master_bit_sequencer_core i2cbs_checker u_i2cbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
